@@ hw/rtl/gdtdc_pkg.sv @@
// ----------------------------------------------------------------------------
// gdtdc_pkg - shared definitions for the Gregorian date to day count block
// Calendar constants, the per-date evaluation function and the record types
// used by the top level.
// ----------------------------------------------------------------------------
package gdtdc_pkg;

  // Calendar constants
  localparam int MAX_YEAR      = 4095;
  localparam int EPOCH_YEAR    = 1970;
  localparam int DAYS_PER_YEAR = 365;
  localparam int FEB_LEAP      = 29;
  localparam int FEB_COMMON    = 28;
  localparam int SHORT_MONTH   = 30;
  localparam int LONG_MONTH    = 31;
  localparam int EPOCH_WEEKDAY = 5;  // 1970-01-01 was a Thursday; 0 is Saturday

  // Leap years in 1 .. EPOCH_YEAR-1
  localparam int LEAPS_BEFORE_EPOCH =
    (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;

  // Field widths
  localparam int DAY_W   = 6;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int COUNT_W = 20;
  localparam int WDAY_W  = 3;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // floor(q / 25) for q below 1024: (q * 1311) >> 15, error stays under 1/100
  localparam int RECIP25       = 1311;
  localparam int RECIP25_SHIFT = 15;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic [WDAY_W-1:0]  weekday;
  } date_res_t;

  typedef struct packed {
    logic               first_valid;
    logic               second_valid;
    logic [COUNT_W-1:0] first_day_count;
    logic [WDAY_W-1:0]  first_weekday;
    logic [COUNT_W-1:0] day_distance;
  } result_t;

  // Days before the first of the month in a common year
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mo);
    logic [8:0] off;
    unique case (mo)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  function automatic logic [4:0] month_length(input logic [MONTH_W-1:0] mo,
                                              input logic leap);
    logic [4:0] len;
    case (mo) inside
      MONTH_FEB:                 len = leap ? 5'(FEB_LEAP) : 5'(FEB_COMMON);
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'(SHORT_MONTH);
      default:                   len = 5'(LONG_MONTH);
    endcase
    return len;
  endfunction

  // x mod 7 by folding octal digits (8 is 1 mod 7)
  function automatic logic [WDAY_W-1:0] mod7(input logic [11:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]);
    t = 4'(s[2:0]) + 4'(s[4:3]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[WDAY_W-1:0];
  endfunction

  // Validity, day count since the epoch and weekday of one date
  function automatic date_res_t date_eval(input date_t dt);
    date_res_t  r;
    logic [YEAR_W-1:0]  n;
    logic [9:0]         q4;
    logic [20:0]        prod;
    logic [5:0]         q100;
    logic [9:0]         r25;
    logic               div4;
    logic               div100;
    logic               div400;
    logic               leap;
    logic               extra;
    logic [4:0]         mlen;
    logic [8:0]         off;
    logic [YEAR_W-1:0]  yrs;
    logic [9:0]         leaps;
    logic [11:0]        wsum;
    n     = dt.year - 12'd1;
    q4    = n[11:2];
    prod  = 21'(q4) * 21'(RECIP25);
    q100  = prod[20:RECIP25_SHIFT];
    r25   = q4 - 10'(q100) * 10'd25;
    // (y-1)/4 is 24 mod 25 exactly when a multiple of 4 is a multiple of 100
    div4   = (dt.year[1:0] == 2'b00);
    div100 = div4 && (r25 == 10'd24);
    div400 = div100 && (q100[1:0] == 2'b11);
    leap   = div4 && (!div100 || div400);
    mlen   = month_length(dt.month, leap);
    off    = month_offset(dt.month);
    extra  = leap && (dt.month > MONTH_FEB);
    yrs    = dt.year - 12'(EPOCH_YEAR);
    leaps  = q4 - 10'(q100) + 10'(q100[5:2]) - 10'(LEAPS_BEFORE_EPOCH);
    r.count = 20'(yrs) * 20'(DAYS_PER_YEAR) + 20'(leaps) + 20'(off)
            + 20'(extra) + 20'(dt.day) - 20'd1;
    // 365 is 1 mod 7, so the weekday follows from a short sum
    wsum = yrs + 12'(leaps) + 12'(off) + 12'(extra) + 12'(dt.day)
         + 12'(EPOCH_WEEKDAY - 1);
    r.weekday = mod7(wsum);
    r.valid = (dt.month >= MONTH_JAN) && (dt.month <= MONTH_DEC)
           && (32'(dt.year) >= 32'(EPOCH_YEAR)) && (32'(dt.year) <= 32'(MAX_YEAR))
           && (dt.day != 6'd0) && (dt.day <= 6'(mlen));
    return r;
  endfunction

endpackage

@@ hw/rtl/gregorian_date_to_day_count.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_to_day_count - day numbers of a pair of Gregorian dates
// Checks two dates, gives the first one's day count since 1970-01-01 and its
// weekday, and the absolute distance in days between the two.
// ----------------------------------------------------------------------------
// Each transaction on the input carries two dates; each produces exactly one
// result transaction. A date is valid when its month is 1 to 12, its day lies
// within that month (February has 29 days in leap years) and its year is 1970
// or later. The day count of 1970-01-01 is 0 and the weekday is coded 0 for
// Saturday through 6 for Friday. An invalid first date gives zero count and
// weekday; if either date is invalid the distance is zero. The block is a
// two-register pipeline: an input register feeds the calendar arithmetic,
// whose result lands in an output register and is shown there until taken.
// A new pair is taken every cycle as long as the output side keeps taking
// results. A stall on the output holds the output register, and in_tready
// drops only when both registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module gregorian_date_to_day_count (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // first_day[5:0], first_month[9:6], first_year[21:10],
  // second_day[27:22], second_month[31:28], second_year[43:32], zero pad
  input  logic [gdtdc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // first_day_count[19:0], first_weekday[22:20], day_distance[42:23], zero pad
  output logic [gdtdc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // first_valid[0], second_valid[1]
  output logic [gdtdc_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  logic                  in_vld_r;
  gdtdc_pkg::date_t      first_r;
  gdtdc_pkg::date_t      second_r;
  logic                  out_vld_r;
  gdtdc_pkg::result_t    res_r;
  gdtdc_pkg::result_t    res_nxt;
  gdtdc_pkg::date_res_t  first_eval;
  gdtdc_pkg::date_res_t  second_eval;
  logic                  out_adv;

  // Advance the output register when it is empty or being drained
  assign out_adv   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || out_adv;

  // Input register: hold the two dates until the result register takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      first_r  <= '{day:   in_tdata[5:0],
                    month: in_tdata[9:6],
                    year:  in_tdata[21:10]};
      second_r <= '{day:   in_tdata[27:22],
                    month: in_tdata[31:28],
                    year:  in_tdata[43:32]};
    end
  end

  // Calendar arithmetic for both dates in parallel
  always_comb begin
    first_eval  = gdtdc_pkg::date_eval(first_r);
    second_eval = gdtdc_pkg::date_eval(second_r);
    res_nxt.first_valid     = first_eval.valid;
    res_nxt.second_valid    = second_eval.valid;
    res_nxt.first_day_count = first_eval.valid ? first_eval.count : '0;
    res_nxt.first_weekday   = first_eval.valid ? first_eval.weekday : '0;
    if (first_eval.valid && second_eval.valid) begin
      res_nxt.day_distance = (second_eval.count >= first_eval.count) ?
                             (second_eval.count - first_eval.count) :
                             (first_eval.count - second_eval.count);
    end else begin
      res_nxt.day_distance = '0;
    end
  end

  // Output register: drop the old result once taken, load the next one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, res_r.day_distance, res_r.first_weekday,
                       res_r.first_day_count};
  assign out_tuser  = {res_r.second_valid, res_r.first_valid};

endmodule

@@ hw/rtl/gdtdc_checker.sv @@
// ----------------------------------------------------------------------------
// gdtdc_checker - port-level checks for the date to day count block
// Checks stall behaviour, zeroed invalid results, weekday range and padding.
// ----------------------------------------------------------------------------
module gdtdc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [gdtdc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [gdtdc_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser))
    else $error("result changed while stalled");

  // Invalid first date reports zero count and weekday
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[22:0] == 23'd0)
    else $error("invalid first date with non-zero count or weekday");

  // Any invalid date zeroes the distance
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (!out_tuser[0] || !out_tuser[1]) |-> out_tdata[42:23] == 20'd0)
    else $error("distance non-zero with an invalid date");

  // Weekday code stays within Saturday to Friday and padding stays clear
  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:20] != 3'd7 && out_tdata[47:43] == 5'd0)
    else $error("weekday code out of range or padding set");

endmodule

bind gregorian_date_to_day_count gdtdc_checker u_gdtdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
